// ===== src/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and the priority function of the
// infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_NOT   = 8'h21;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam int SYM_W  = 8;
    localparam int USER_W = 3;

    localparam int USR_NO_SYMBOL = 0;
    localparam int USR_EXPR_LAST = 1;
    localparam int USR_OVERFLOW  = 2;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic             no_symbol;
        logic             run_last;
        logic             expr_last;
        logic             overflow;
    } itp_result_t;

    function automatic logic [1:0] sym_prio(input logic [SYM_W-1:0] c);
        logic [1:0] p;
        if (c == CH_OPEN)
        begin
            p = 2'd0;
        end
        else if (c == CH_NOT)
        begin
            p = 2'd2;
        end
        else
        begin
            p = 2'd1;
        end
        return p;
    endfunction

endpackage

// ===== src/infix_to_postfix_converter_core.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
// An operand letter or '(' goes from IDLE straight to DONE. A ')' or an
// operator first pops in CLOSE or OPER each symbol it emits, and in DONE an
// expression end pops every entry left on the stack. The pace is set by the
// operator stack memory, which gives one entry per cycle through its single
// read port, and by the one-entry output register; a stalled output stream
// holds the sequencer. The stack needs no clearing after reset.
// A push onto a full stack is dropped and reported as overflow on the final
// result of the expression.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [itp_pkg::SYM_W-1:0]    s_tdata,   // [7:0] symbol
    input  logic                         s_tlast,   // expr_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [itp_pkg::SYM_W-1:0]    m_tdata,   // [7:0] out_symbol
    output logic                         m_tlast,   // run_last
    output logic [itp_pkg::USER_W-1:0]   m_tuser    // [0] no_symbol, [1] expr_last, [2] overflow
);
    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLOSE = 2'd1;
    localparam logic [1:0] S_OPER  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             end_reg, end_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic             fwd_reg;
    logic [SYM_W-1:0] fwd_data_reg;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [SYM_W-1:0] wdata;
    logic [AW-1:0]    raddr;
    logic [SYM_W-1:0] rdata;
    logic [SYM_W-1:0] top_sym;
    logic [CW-1:0]    raddr_full;

    logic             out_push;
    itp_result_t      out_data;
    logic             out_free;

    logic             full;
    logic             empty;
    logic             can_put;

    assign top_sym    = fwd_reg ? fwd_data_reg : rdata;
    assign full       = (count_reg == CW'(STACK_DEPTH));
    assign empty      = (count_reg == '0);
    assign can_put    = !pend_valid_reg || out_free;
    assign waddr      = count_reg[AW-1:0];
    assign raddr_full = count_next - CW'(1);
    assign raddr      = raddr_full[AW-1:0];
    assign s_tready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        end_next        = end_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        we              = 1'b0;
        wdata           = sym_reg;
        out_push        = 1'b0;
        out_data        = '{out_symbol: pend_sym_reg, no_symbol: 1'b0, run_last: 1'b0,
                            expr_last: 1'b0, overflow: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    sym_next = s_tdata;
                    end_next = s_tlast;
                    wdata    = s_tdata;
                    if (s_tdata inside {[CH_A:CH_Z]})
                    begin
                        pend_valid_next = 1'b1;
                        pend_sym_next   = s_tdata;
                        state_next      = S_DONE;
                    end
                    else if (s_tdata == CH_OPEN)
                    begin
                        if (full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            we         = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        state_next = S_DONE;
                    end
                    else if (s_tdata == CH_CLOSE)
                    begin
                        state_next = S_CLOSE;
                    end
                    else
                    begin
                        state_next = S_OPER;
                    end
                end
            end

            S_CLOSE:
            begin
                if (empty)
                begin
                    state_next = S_DONE;
                end
                else if (top_sym == CH_OPEN)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else if (can_put)
                begin
                    out_push        = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_sym_next   = top_sym;
                    count_next      = count_reg - CW'(1);
                end
            end

            S_OPER:
            begin
                if (!empty && (sym_prio(sym_reg) <= sym_prio(top_sym)))
                begin
                    if (can_put)
                    begin
                        out_push        = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_sym_next   = top_sym;
                        count_next      = count_reg - CW'(1);
                    end
                end
                else
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (end_reg && !empty)
                begin
                    if (can_put)
                    begin
                        out_push        = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_sym_next   = top_sym;
                        count_next      = count_reg - CW'(1);
                    end
                end
                else if (pend_valid_reg || end_reg)
                begin
                    if (out_free)
                    begin
                        out_push           = 1'b1;
                        out_data.out_symbol = pend_valid_reg ? pend_sym_reg : '0;
                        out_data.no_symbol = !pend_valid_reg;
                        out_data.run_last  = 1'b1;
                        out_data.expr_last = end_reg;
                        out_data.overflow  = end_reg && ovf_reg;
                        pend_valid_next    = 1'b0;
                        if (end_reg)
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            end_reg        <= 1'b0;
            fwd_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            end_reg        <= end_next;
            fwd_reg        <= we && (waddr == raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        pend_sym_reg <= pend_sym_next;
        fwd_data_reg <= wdata;
    end

    itp_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    itp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (out_push),
        .din      (out_data),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== src/itp_stack_ram.sv =====
// ----------------------------------------------------------------------------
// itp_stack_ram
// Operator stack storage: one write port, one read port, registered read
// data.
// ----------------------------------------------------------------------------
module itp_stack_ram #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [itp_pkg::SYM_W-1:0]  wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [itp_pkg::SYM_W-1:0]  rdata
);
    import itp_pkg::*;

    logic [SYM_W-1:0] mem [DEPTH];
    logic [SYM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/itp_out_reg.sv =====
// ----------------------------------------------------------------------------
// itp_out_reg
// Output register of the result stream; frees the control logic from the
// downstream handshake.
// ----------------------------------------------------------------------------
module itp_out_reg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  itp_pkg::itp_result_t         din,
    output logic                         free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [itp_pkg::SYM_W-1:0]    m_tdata,   // [7:0] out_symbol
    output logic                         m_tlast,   // run_last
    output logic [itp_pkg::USER_W-1:0]   m_tuser    // [0] no_symbol, [1] expr_last, [2] overflow
);
    import itp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    itp_result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= din;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.out_symbol;
    assign m_tlast  = data_reg.run_last;
    assign m_tuser  = {data_reg.overflow, data_reg.expr_last, data_reg.no_symbol};

endmodule

// ===== src/itp_checker.sv =====
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks on the result stream of the converter.
// ----------------------------------------------------------------------------
module itp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [itp_pkg::SYM_W-1:0]    m_tdata,
    input logic                         m_tlast,
    input logic [itp_pkg::USER_W-1:0]   m_tuser
);
    import itp_pkg::*;

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_marker_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USR_NO_SYMBOL] |-> m_tdata == '0 && m_tuser[USR_EXPR_LAST]
            && m_tlast)
        else $error("end marker malformed");

    a_expr_last_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USR_EXPR_LAST] |-> m_tlast)
        else $error("expression end without request end");

    a_overflow_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USR_OVERFLOW] |-> m_tuser[USR_EXPR_LAST])
        else $error("overflow outside final result");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== test/infix_to_postfix_converter_core_tb.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core_tb
// Feeds infix character streams into the converter and checks every postfix
// character against a shunting-yard predictor run at request acceptance.
// Covers operand pass-through, operator priority pops, parenthesis matching,
// unmatched brackets, empty expression ends and stack overflow, with random
// source idling and sink backpressure in several phases.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    localparam int STACK_DEPTH  = 16;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_ITEMS  = 55;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [7:0] OP_ADD = 8'h2B;
    localparam logic [7:0] OP_SUB = 8'h2D;
    localparam logic [7:0] OP_MUL = 8'h2A;
    localparam logic [7:0] OP_DIV = 8'h2F;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } char_req_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SYM_W-1:0]    s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [SYM_W-1:0]    m_tdata;
    logic                m_tlast;
    logic [USER_W-1:0]   m_tuser;

    char_req_t   pend_q[$];
    itp_result_t postfix_q[$];

    logic [SYM_W-1:0] op_stk[STACK_DEPTH];
    int               stk_cnt;
    logic             ovf_seen;

    int sender_idle    = 0;
    int receiver_stall = 0;
    int err_cnt        = 0;
    int sent_cnt       = 0;
    int result_cnt     = 0;
    int expr_cnt       = 0;
    int ovf_cnt        = 0;
    int deepest        = 0;
    int cycles         = 0;

    infix_to_postfix_converter_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int rank(input logic [SYM_W-1:0] c);
        if (c == CH_OPEN)
        begin
            return 0;
        end
        if (c == CH_NOT)
        begin
            return 2;
        end
        return 1;
    endfunction

    task automatic shunt_symbol(input logic [SYM_W-1:0] sym, input logic last);
        logic [SYM_W-1:0] emit_buf[STACK_DEPTH+1];
        logic             none_buf[STACK_DEPTH+1];
        int               n;
        logic             ovf;
        itp_result_t      r;
        n = 0;
        if (sym >= CH_A && sym <= CH_Z)
        begin
            emit_buf[n] = sym;
            none_buf[n] = 1'b0;
            n++;
        end
        else if (sym == CH_OPEN)
        begin
            if (stk_cnt >= STACK_DEPTH)
            begin
                ovf_seen = 1'b1;
            end
            else
            begin
                op_stk[stk_cnt] = sym;
                stk_cnt++;
            end
        end
        else if (sym == CH_CLOSE)
        begin
            while (stk_cnt > 0)
            begin
                stk_cnt--;
                if (op_stk[stk_cnt] == CH_OPEN)
                begin
                    break;
                end
                emit_buf[n] = op_stk[stk_cnt];
                none_buf[n] = 1'b0;
                n++;
            end
        end
        else
        begin
            while (stk_cnt > 0 && rank(sym) <= rank(op_stk[stk_cnt-1]))
            begin
                stk_cnt--;
                emit_buf[n] = op_stk[stk_cnt];
                none_buf[n] = 1'b0;
                n++;
            end
            if (stk_cnt >= STACK_DEPTH)
            begin
                ovf_seen = 1'b1;
            end
            else
            begin
                op_stk[stk_cnt] = sym;
                stk_cnt++;
            end
        end
        if (stk_cnt > deepest)
        begin
            deepest = stk_cnt;
        end
        ovf = ovf_seen;
        if (last)
        begin
            while (stk_cnt > 0)
            begin
                stk_cnt--;
                emit_buf[n] = op_stk[stk_cnt];
                none_buf[n] = 1'b0;
                n++;
            end
            if (n == 0)
            begin
                emit_buf[n] = '0;
                none_buf[n] = 1'b1;
                n++;
            end
            expr_cnt++;
            if (ovf)
            begin
                ovf_cnt++;
            end
            stk_cnt  = 0;
            ovf_seen = 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            r.out_symbol = emit_buf[i];
            r.no_symbol  = none_buf[i];
            r.run_last   = (i == n - 1);
            r.expr_last  = last && (i == n - 1);
            r.overflow   = last && (i == n - 1) && ovf;
            postfix_q.insert(postfix_q.size(), r);
        end
    endtask

    always @(posedge clk)
    begin : drive_blk
        char_req_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                shunt_symbol(s_tdata, s_tlast);
                sent_cnt++;
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the pending request
            end
            else if (pend_q.size() != 0 && $urandom_range(99) >= sender_idle)
            begin
                nxt = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.sym;
                s_tlast  <= nxt.last;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_blk
        itp_result_t want;
        logic        bad;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_cnt++;
                if (postfix_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result sym=%h last=%b user=%b",
                             $time, m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = postfix_q.pop_front();
                    bad = (m_tdata !== want.out_symbol)
                        || (m_tuser[USR_NO_SYMBOL] !== want.no_symbol)
                        || (m_tlast !== want.run_last)
                        || (m_tuser[USR_EXPR_LAST] !== want.expr_last)
                        || (m_tuser[USR_OVERFLOW] !== want.overflow);
                    if (bad)
                    begin
                        err_cnt++;
                        $display("%0t: mismatch expected sym=%h none=%b run_last=%b %s%b %s%b",
                                 $time, want.out_symbol, want.no_symbol, want.run_last,
                                 "expr_last=", want.expr_last, "ovf=", want.overflow);
                        $display("%0t: mismatch got sym=%h none=%b run_last=%b %s%b %s%b",
                                 $time, m_tdata, m_tuser[USR_NO_SYMBOL], m_tlast,
                                 "expr_last=", m_tuser[USR_EXPR_LAST],
                                 "ovf=", m_tuser[USR_OVERFLOW]);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("infix_to_postfix_converter_core_tb: errors");
            $finish;
        end
    end

    task automatic add_item(input logic [SYM_W-1:0] sym, input logic last);
        char_req_t c;
        c.sym  = sym;
        c.last = last;
        pend_q.insert(pend_q.size(), c);
    endtask

    function automatic logic [SYM_W-1:0] any_operator();
        case ($urandom_range(5))
            0: return CH_NOT;
            1: return OP_ADD;
            2: return OP_SUB;
            3: return OP_MUL;
            4: return OP_DIV;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] any_letter();
        return 8'($urandom_range(CH_A, CH_Z));
    endfunction

    task automatic fill_random(input int count);
        int added;
        int len;
        int pick;
        int pairs;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(99);
            if (pick < 72)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 40)
                    begin
                        add_item(any_letter(), i == len - 1);
                    end
                    else if (pick < 65)
                    begin
                        add_item(any_operator(), i == len - 1);
                    end
                    else if (pick < 83)
                    begin
                        add_item(CH_OPEN, i == len - 1);
                    end
                    else
                    begin
                        add_item(CH_CLOSE, i == len - 1);
                    end
                end
                added += len;
            end
            else if (pick < 84)
            begin
                // nest deep, sometimes filling the stack and sometimes past full
                pairs = $urandom_range(6, 10);
                for (int i = 0; i < pairs; i++)
                begin
                    add_item(CH_OPEN, 1'b0);
                    add_item(any_operator() == CH_NOT ? CH_NOT : OP_MUL, 1'b0);
                end
                add_item(any_letter(), 1'b1);
                added += 2 * pairs + 1;
            end
            else
            begin
                add_item(8'($urandom_range(255)), $urandom_range(7) == 0);
                added++;
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        @(negedge clk);
        sender_idle    = idle_pct;
        receiver_stall = stall_pct;
        fill_random(PHASE_ITEMS);
        while (pend_q.size() != 0 || s_tvalid || postfix_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        stk_cnt  = 0;
        ovf_seen = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        add_item(CH_A, 1'b1);
        add_item(CH_CLOSE, 1'b1);
        add_item(CH_OPEN, 1'b0);
        add_item(CH_A, 1'b0);
        add_item(OP_ADD, 1'b0);
        add_item("B", 1'b0);
        add_item(CH_CLOSE, 1'b0);
        add_item(CH_NOT, 1'b0);
        add_item("C", 1'b0);
        add_item(8'h00, 1'b0);
        add_item(CH_Z, 1'b0);
        add_item(CH_NOT, 1'b0);
        add_item(CH_NOT, 1'b0);
        add_item(8'hFF, 1'b1);
        add_item(CH_OPEN, 1'b0);
        add_item(8'h80, 1'b0);
        add_item(CH_CLOSE, 1'b0);
        add_item(CH_CLOSE, 1'b0);
        add_item(CH_OPEN, 1'b1);
        add_item(OP_DIV, 1'b0);
        add_item(8'h7F, 1'b1);

        run_phase(0, 0);
        run_phase(61, 0);
        run_phase(0, 61);
        run_phase(28, 28);

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d characters in %0d expressions, checked %0d postfix results",
                 sent_cnt, expr_cnt, result_cnt);
        $display("%0d expressions ended in overflow, deepest stack %0d of %0d",
                 ovf_cnt, deepest, STACK_DEPTH);
        if (err_cnt == 0 && postfix_q.size() == 0)
        begin
            $display("infix_to_postfix_converter_core_tb: clean");
        end
        else
        begin
            $display("infix_to_postfix_converter_core_tb: errors");
        end
        $finish;
    end

endmodule
